>>> rtl/psfs_pkg.sv
package psfs_pkg;

   // Field widths fixed by the bus protocol
   localparam int BYTE_WIDTH      = 8;
   localparam int POLICY_WIDTH    = 2;
   localparam int TOTAL_WIDTH     = 16;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int IDLE_WIDTH      = 4;

   // Default sizes of the counters
   localparam int DEFAULT_COUNT_WIDTH = 8;
   localparam int DEFAULT_ERROR_WIDTH = 16;

   // Reset values
   localparam logic [BYTE_WIDTH-1:0]   BUS_ADDRESS_RESET  = 8'd0;
   localparam logic [BYTE_WIDTH-1:0]   LAST_COUNT_RESET   = 8'd129;
   localparam logic [BYTE_WIDTH-1:0]   RESYNC_RESET       = 8'd0;
   localparam logic [BYTE_WIDTH-1:0]   COMPARE_SLOT_RESET = 8'd3;

   // Idle tick milestones
   localparam logic [IDLE_WIDTH-1:0] IDLE_FIRST  = 4'd1;
   localparam logic [IDLE_WIDTH-1:0] IDLE_RESYNC = 4'd3;
   localparam logic [IDLE_WIDTH-1:0] IDLE_PARITY = 4'd5;
   localparam logic [IDLE_WIDTH-1:0] IDLE_LOSS   = 4'd7;
   localparam logic [IDLE_WIDTH-1:0] IDLE_MAX    = 4'd15;

   typedef enum logic [1:0] {
      REQ_PULSE = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_LOAD  = 2'd2
   } psfs_req_code_type;

   typedef enum logic [POLICY_WIDTH-1:0] {
      POLICY_IGNORE  = 2'd0,
      POLICY_IF_SENT = 2'd1,
      POLICY_ALWAYS  = 2'd2
   } psfs_policy_type;

   typedef enum logic [2:0] {
      REG_BUS_ADDRESS  = 3'd0,
      REG_LAST_COUNT   = 3'd1,
      REG_RESYNC_VALUE = 3'd2,
      REG_PARITY_POL   = 3'd3,
      REG_PULSE_POL    = 3'd4
   } psfs_reg_type;

   localparam logic [POLICY_WIDTH-1:0] PARITY_POLICY_RESET = POLICY_IF_SENT;
   localparam logic [POLICY_WIDTH-1:0] PULSE_POLICY_RESET  = POLICY_ALWAYS;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [BYTE_WIDTH-1:0] send_byte;
   } psfs_req_type;

   typedef struct packed {
      logic                   tx_valid;
      logic [BYTE_WIDTH-1:0]  tx_byte;
      logic                   cycle_end;
      logic                   link_ok;
      logic                   byte_waiting;
      logic [TOTAL_WIDTH-1:0] parity_error_total;
      logic [TOTAL_WIDTH-1:0] pulse_error_total;
   } psfs_rsp_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]   bus_address;
      logic [BYTE_WIDTH-1:0]   cycle_last_count;
      logic [BYTE_WIDTH-1:0]   resync_value;
      logic [POLICY_WIDTH-1:0] parity_policy;
      logic [POLICY_WIDTH-1:0] pulse_error_policy;
   } psfs_cfg_type;

   // Sync flag after an error under the given policy; unknown codes ignore
   function automatic logic policy_sync(logic [POLICY_WIDTH-1:0] policy,
                                        logic just_sent, logic sync);
      logic result;
      result = sync;
      case (policy)
         POLICY_IF_SENT: result = sync & ~just_sent;
         POLICY_ALWAYS:  result = 1'b0;
         default:        result = sync;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/poll_slot_feedback_sender_unit.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_data  (psfs_req_type)
// rsp       out        rsp_valid / rsp_ready   rsp_data  (psfs_rsp_type)
// csr       in         psel penable pwrite     paddr pwdata -> prdata (pready tied high)
//
// One item per cycle: a request is worked in one pass through the state
// update logic and its result lands in the output register, or in the skid
// register while rsp is stalled. The skid register holds one result during an
// rsp stall so requests keep flowing; req_ready drops only while it is full.
// Synchronous reset sets all control state and the configuration registers to their reset values.
module poll_slot_feedback_sender_unit #(
   parameter int COUNT_WIDTH       = psfs_pkg::DEFAULT_COUNT_WIDTH,
   parameter int ERROR_COUNT_WIDTH = psfs_pkg::DEFAULT_ERROR_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  psfs_pkg::psfs_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output psfs_pkg::psfs_rsp_type                rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [psfs_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [psfs_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [psfs_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);
   import psfs_pkg::*;

   psfs_cfg_type cfg_ff;
   psfs_reg_type reg_index;
   logic         csr_write;

   logic         req_transfer;
   psfs_rsp_type step_rsp;

   logic         out_valid_ff, out_valid_in;
   psfs_rsp_type out_data_ff, out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   psfs_rsp_type skid_data_ff, skid_data_in;

   // Configuration registers
   assign pready    = 1'b1;
   assign reg_index = psfs_reg_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_address        <= BUS_ADDRESS_RESET;
         cfg_ff.cycle_last_count   <= LAST_COUNT_RESET;
         cfg_ff.resync_value       <= RESYNC_RESET;
         cfg_ff.parity_policy      <= PARITY_POLICY_RESET;
         cfg_ff.pulse_error_policy <= PULSE_POLICY_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_BUS_ADDRESS:  cfg_ff.bus_address        <= pwdata[BYTE_WIDTH-1:0];
            REG_LAST_COUNT:   cfg_ff.cycle_last_count   <= pwdata[BYTE_WIDTH-1:0];
            REG_RESYNC_VALUE: cfg_ff.resync_value       <= pwdata[BYTE_WIDTH-1:0];
            REG_PARITY_POL:   cfg_ff.parity_policy      <= pwdata[POLICY_WIDTH-1:0];
            REG_PULSE_POL:    cfg_ff.pulse_error_policy <= pwdata[POLICY_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_BUS_ADDRESS:  prdata = CSR_DATA_WIDTH'(cfg_ff.bus_address);
         REG_LAST_COUNT:   prdata = CSR_DATA_WIDTH'(cfg_ff.cycle_last_count);
         REG_RESYNC_VALUE: prdata = CSR_DATA_WIDTH'(cfg_ff.resync_value);
         REG_PARITY_POL:   prdata = CSR_DATA_WIDTH'(cfg_ff.parity_policy);
         REG_PULSE_POL:    prdata = CSR_DATA_WIDTH'(cfg_ff.pulse_error_policy);
         default:          prdata = '0;
      endcase
   end

   // Request path
   assign req_ready    = ~skid_valid_ff;
   assign req_transfer = req_valid & req_ready;

   psfs_engine #(
      .COUNT_WIDTH       (COUNT_WIDTH),
      .ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (req_transfer),
      .req     (req_data),
      .cfg     (cfg_ff),
      .rsp     (step_rsp)
   );

   // Output register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            // drain the skid entry first; no transfer can come in this cycle
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_transfer;
            out_data_in  = step_rsp;
         end
      end else if (req_transfer) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> rtl/psfs_engine.sv
module psfs_engine #(
   parameter int COUNT_WIDTH       = psfs_pkg::DEFAULT_COUNT_WIDTH,
   parameter int ERROR_COUNT_WIDTH = psfs_pkg::DEFAULT_ERROR_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  psfs_pkg::psfs_req_type req,
   input  psfs_pkg::psfs_cfg_type cfg,
   output psfs_pkg::psfs_rsp_type rsp
);
   import psfs_pkg::*;

   localparam int CmpWidth = (COUNT_WIDTH > BYTE_WIDTH) ? COUNT_WIDTH : BYTE_WIDTH;

   logic [COUNT_WIDTH-1:0]       pulse_count_ff, pulse_count_in;
   logic [COUNT_WIDTH-1:0]       compare_slot_ff, compare_slot_in;
   logic [COUNT_WIDTH-1:0]       last_tick_count_ff, last_tick_count_in;
   logic [IDLE_WIDTH-1:0]        idle_ticks_ff, idle_ticks_in;
   logic                         sync_ff, sync_in;
   logic                         pending_ff, pending_in;
   logic                         armed_ff, armed_in;
   logic                         sent_ff, sent_in;
   logic                         retry_pulse_ff, retry_pulse_in;
   logic                         retry_parity_ff, retry_parity_in;
   logic [BYTE_WIDTH-1:0]        held_byte_ff, held_byte_in;
   logic [ERROR_COUNT_WIDTH-1:0] parity_err_ff, parity_err_in;
   logic [ERROR_COUNT_WIDTH-1:0] pulse_err_ff, pulse_err_in;

   logic [COUNT_WIDTH-1:0] own_slot;
   logic                   slot_hit;
   logic                   at_wrap;
   logic                   tx_valid;
   logic [BYTE_WIDTH-1:0]  tx_byte;
   logic                   cycle_end;

   assign own_slot = COUNT_WIDTH'(cfg.bus_address);
   assign slot_hit = (pulse_count_ff == compare_slot_ff);
   assign at_wrap  = (CmpWidth'(pulse_count_ff) == CmpWidth'(cfg.cycle_last_count));

   always_comb begin
      pulse_count_in     = pulse_count_ff;
      compare_slot_in    = compare_slot_ff;
      last_tick_count_in = last_tick_count_ff;
      idle_ticks_in      = idle_ticks_ff;
      sync_in            = sync_ff;
      pending_in         = pending_ff;
      armed_in           = armed_ff;
      sent_in            = sent_ff;
      retry_pulse_in     = retry_pulse_ff;
      retry_parity_in    = retry_parity_ff;
      held_byte_in       = held_byte_ff;
      parity_err_in      = parity_err_ff;
      pulse_err_in       = pulse_err_ff;
      tx_valid           = 1'b0;
      tx_byte            = '0;
      cycle_end          = 1'b0;

      case (req.req_type)
         REQ_PULSE: begin
            if (at_wrap) begin
               pulse_count_in = '0;
               cycle_end      = 1'b1;
            end else begin
               pulse_count_in = pulse_count_ff + 1'b1;
            end
            if (slot_hit) begin
               if (armed_ff) begin
                  tx_valid   = 1'b1;
                  tx_byte    = held_byte_ff;
                  pending_in = 1'b0;
                  armed_in   = 1'b0;
                  sent_in    = 1'b1;
               end
               compare_slot_in = own_slot;
            end
         end
         REQ_TICK: begin
            if (pulse_count_ff != last_tick_count_ff) begin
               last_tick_count_in = pulse_count_ff;
               idle_ticks_in      = IDLE_FIRST;
            end else if (idle_ticks_ff != IDLE_MAX) begin
               idle_ticks_in = idle_ticks_ff + 1'b1;
               case (idle_ticks_in)
                  IDLE_RESYNC: begin
                     retry_pulse_in  = sent_ff;
                     retry_parity_in = sent_ff;
                     sent_in         = 1'b0;
                     if (pulse_count_ff == '0) begin
                        sync_in = 1'b1;
                        if (pending_ff && compare_slot_ff == own_slot) begin
                           armed_in = 1'b1;
                        end
                     end else begin
                        // load at once, count the miss only if we were in sync
                        pulse_count_in = COUNT_WIDTH'(cfg.resync_value);
                        if (sync_ff) begin
                           pulse_err_in = pulse_err_ff + 1'b1;
                           sync_in = policy_sync(cfg.pulse_error_policy, sent_ff, sync_ff);
                           if (!sync_in) begin
                              armed_in = 1'b0;
                           end
                        end
                     end
                  end
                  IDLE_PARITY: begin
                     if (sync_ff) begin
                        parity_err_in = parity_err_ff + 1'b1;
                        sync_in = policy_sync(cfg.parity_policy, retry_parity_ff, sync_ff);
                        if (!sync_in) begin
                           armed_in = 1'b0;
                        end
                     end
                  end
                  IDLE_LOSS: begin
                     // signal lost: take back the parity error counted before
                     if (sync_ff) begin
                        parity_err_in = parity_err_ff - 1'b1;
                     end
                     sync_in  = 1'b0;
                     armed_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         REQ_LOAD: begin
            held_byte_in = req.send_byte;
            pending_in   = 1'b1;
         end
         default: begin
         end
      endcase

      rsp.tx_valid           = tx_valid;
      rsp.tx_byte            = tx_byte;
      rsp.cycle_end          = cycle_end;
      rsp.link_ok            = sync_in;
      rsp.byte_waiting       = pending_in;
      rsp.parity_error_total = TOTAL_WIDTH'(parity_err_in);
      rsp.pulse_error_total  = TOTAL_WIDTH'(pulse_err_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff     <= '0;
         compare_slot_ff    <= COUNT_WIDTH'(COMPARE_SLOT_RESET);
         last_tick_count_ff <= '0;
         idle_ticks_ff      <= '0;
         sync_ff            <= 1'b0;
         pending_ff         <= 1'b0;
         armed_ff           <= 1'b0;
         sent_ff            <= 1'b0;
         retry_pulse_ff     <= 1'b0;
         retry_parity_ff    <= 1'b0;
         parity_err_ff      <= '0;
         pulse_err_ff       <= '0;
      end else if (advance) begin
         pulse_count_ff     <= pulse_count_in;
         compare_slot_ff    <= compare_slot_in;
         last_tick_count_ff <= last_tick_count_in;
         idle_ticks_ff      <= idle_ticks_in;
         sync_ff            <= sync_in;
         pending_ff         <= pending_in;
         armed_ff           <= armed_in;
         sent_ff            <= sent_in;
         retry_pulse_ff     <= retry_pulse_in;
         retry_parity_ff    <= retry_parity_in;
         parity_err_ff      <= parity_err_in;
         pulse_err_ff       <= pulse_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

>>> rtl/psfs_checker.sv
module psfs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input psfs_pkg::psfs_rsp_type rsp_data
);
   import psfs_pkg::*;

   // Requests accepted whose results are not yet taken
   logic [1:0] open_ff, open_in;

   always_comb begin
      open_in = open_ff;
      if ((req_valid & req_ready) && !(rsp_valid & rsp_ready)) begin
         open_in = open_ff + 1'b1;
      end else if (!(req_valid & req_ready) && (rsp_valid & rsp_ready)) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_result_matches_backlog: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == (open_ff != 2'd0))
      else $error("result valid does not match outstanding transfers");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> open_ff == 2'd2)
      else $error("request stalled with room in the output stages");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind poll_slot_feedback_sender_unit psfs_checker u_psfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
